// ===== sv/length_prefixed_deframer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Length-prefixed deframer assertion macros
// Shared property forms for the deframer core's checks.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_DEFRAMER_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_DEFRAMER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define LPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed in the following cycle");

`endif

// ===== sv/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Length-prefixed deframer package
// Result codes, header constants and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_BODY  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Header layout: four length bytes, then two type bytes.
    localparam logic [2:0] HEADER_BYTES    = 3'd6;
    localparam logic [2:0] LEN_FIELD_BYTES = 3'd4;

    // Reset value of the maximum body length register.
    localparam logic [31:0] RESET_MAX_BODY = 32'd16777216;

    // One result word.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] packet_type;
        logic [7:0]  body_byte;
        logic        last;
    } lpd_result_t;

endpackage

`default_nettype wire

// ===== sv/lpd_if.sv =====
// ----------------------------------------------------------------------------
// Length-prefixed deframer channel interfaces
// Valid/ready channels for received bytes, result words and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Received byte stream.
interface lpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// Deframed result words.
interface lpd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] packet_type;
    logic [7:0]  body_byte;
    logic        last;

    modport source (output valid, output kind, output packet_type, output body_byte,
                    output last, input ready);
    modport sink   (input valid, input kind, input packet_type, input body_byte,
                    input last, output ready);
endinterface

// Write channel for the maximum body length register.
interface lpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/length_prefixed_deframer_core.sv =====
// A result word is registered in the output register, or in the skid entry during an output stall.
// Throughput: one byte per cycle while the skid entry is empty; the header compare and body count settle in that cycle.
// A two-entry output stage (output register plus skid) takes one more word during an
// output stall; the input is held off while the skid entry is full.
// Reset clears the header count, body count and halt flag, empties the output stage,
// and sets the maximum body length back to 16777216.
// ----------------------------------------------------------------------------
// Length-prefixed deframer core
// Splits a byte stream into packets with a 32-bit length and 16-bit type header.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_deframer_core
    import lpd_pkg::*;
(
    input  wire           clk,
    input  wire           rst_n,
    lpd_byte_if.sink      rx,
    lpd_result_if.source  packets,
    lpd_cfg_if.sink       cfg
);

    // Register state.
    logic [31:0] max_body_reg;
    logic [2:0]  header_count_reg, header_count_next;
    logic [31:0] length_shift_reg, length_shift_next;
    logic [15:0] type_shift_reg, type_shift_next;
    logic [31:0] body_remaining_reg, body_remaining_next;
    logic        halted_reg, halted_next;

    logic        out_valid_reg;
    lpd_result_t out_reg;
    logic        skid_valid_reg;
    lpd_result_t skid_reg;

    logic        accept;
    logic        res_valid;
    lpd_result_t res;
    logic [2:0]  count_inc;
    logic        load_out;

    assign accept    = rx.valid && rx.ready;
    assign rx.ready  = !skid_valid_reg;
    assign cfg.ready = 1'b1;
    assign count_inc = header_count_reg + 3'd1;
    assign load_out  = !out_valid_reg || packets.ready;

    // Header assembly, length check and body counting for one byte.
    always_comb
    begin
        header_count_next   = header_count_reg;
        length_shift_next   = length_shift_reg;
        type_shift_next     = type_shift_reg;
        body_remaining_next = body_remaining_reg;
        halted_next         = halted_reg;
        res_valid           = 1'b0;
        res.kind            = KIND_BODY;
        res.packet_type     = type_shift_reg;
        res.body_byte       = 8'd0;
        res.last            = 1'b0;

        if (accept && !halted_reg)
        begin
            if (header_count_reg < HEADER_BYTES)
            begin
                if (header_count_reg < LEN_FIELD_BYTES)
                begin
                    length_shift_next = {length_shift_reg[23:0], rx.data_byte};
                end
                else
                begin
                    type_shift_next = {type_shift_reg[7:0], rx.data_byte};
                end
                header_count_next = count_inc;
                res.packet_type   = type_shift_next;

                // The header completes on its sixth byte.
                if (count_inc == HEADER_BYTES)
                begin
                    if (length_shift_next > max_body_reg)
                    begin
                        halted_next = 1'b1;
                        res_valid   = 1'b1;
                        res.kind    = KIND_ERROR;
                        res.last    = 1'b1;
                    end
                    else if (length_shift_next == 32'd0)
                    begin
                        header_count_next = 3'd0;
                        res_valid         = 1'b1;
                        res.kind          = KIND_EMPTY;
                        res.last          = 1'b1;
                    end
                    else
                    begin
                        body_remaining_next = length_shift_next;
                    end
                end
            end
            else
            begin
                // Body byte: pass it out and count down.
                res_valid     = 1'b1;
                res.kind      = KIND_BODY;
                res.body_byte = rx.data_byte;
                res.last      = (body_remaining_reg <= 32'd1);
                if (body_remaining_reg <= 32'd1)
                begin
                    body_remaining_next = 32'd0;
                    header_count_next   = 3'd0;
                end
                else
                begin
                    body_remaining_next = body_remaining_reg - 32'd1;
                end
            end
        end
    end

    // Deframer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg   <= 3'd0;
            length_shift_reg   <= 32'd0;
            type_shift_reg     <= 16'd0;
            body_remaining_reg <= 32'd0;
            halted_reg         <= 1'b0;
            max_body_reg       <= RESET_MAX_BODY;
        end
        else
        begin
            header_count_reg   <= header_count_next;
            length_shift_reg   <= length_shift_next;
            type_shift_reg     <= type_shift_next;
            body_remaining_reg <= body_remaining_next;
            halted_reg         <= halted_next;
            if (cfg.valid && cfg.ready)
            begin
                max_body_reg <= cfg.data;
            end
        end
    end

    // Output register and skid entry control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output register and skid entry payload.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign packets.valid       = out_valid_reg;
    assign packets.kind        = out_reg.kind;
    assign packets.packet_type = out_reg.packet_type;
    assign packets.body_byte   = out_reg.body_byte;
    assign packets.last        = out_reg.last;

    // Checks on the deframer's own logic.
`include "length_prefixed_deframer_core_defines.svh"

    `LPD_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `LPD_ASSERT_SAME(a_halted_silent, halted_reg, !res_valid)
    `LPD_ASSERT_SAME(a_count_range, 1'b1, header_count_reg <= HEADER_BYTES)
    `LPD_ASSERT_SAME(a_body_gives_word,
                     accept && !halted_reg && header_count_reg == HEADER_BYTES,
                     res_valid && res.kind == KIND_BODY)
    `LPD_ASSERT_NEXT(a_error_halts, res_valid && res.kind == KIND_ERROR, halted_reg)

endmodule

`default_nettype wire
